// ===== design/ijps_pkg.sv =====
// Shared types and constants for the I2C joystick poll sequencer.
`default_nettype none
package ijps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_WAIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_WAIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_ENABLE = 3'd4;

    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd82;
    localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd100;
    localparam logic [7:0]  RST_INIT_WAIT = 8'd10;
    localparam logic [7:0]  RST_DATA_WAIT = 8'd5;
    localparam logic        RST_ACCEL_ENABLE = 1'b1;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_TAKE = 2'd3;

    localparam logic [2:0] REPORT_BYTES = 3'd6;

    localparam logic [7:0] BYTE_INIT_REG   = 8'hF0;
    localparam logic [7:0] BYTE_INIT_VAL   = 8'h55;
    localparam logic [7:0] BYTE_ENC_REG    = 8'hFB;
    localparam logic [7:0] BYTE_ENC_VAL    = 8'h00;
    localparam logic [7:0] BYTE_REQ_REG    = 8'h00;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_STEP,
        OP_DATA,
        OP_TAKE
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_WRITE2 = 2'd1,
        CMD_WRITE1 = 2'd2,
        CMD_READ6  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        PH_SAMPLE_WAIT = 4'd0,
        PH_INIT_WRITE  = 4'd1,
        PH_INIT_WAIT   = 4'd2,
        PH_ENC_WRITE   = 4'd3,
        PH_ENC_WAIT    = 4'd4,
        PH_REQ_WRITE   = 4'd5,
        PH_DATA_WAIT   = 4'd6,
        PH_READ_CMD    = 4'd7,
        PH_AWAIT_DATA  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] bytes_received;
        logic [7:0] joy_x_byte;
        logic [7:0] joy_y_byte;
        logic [7:0] accel_x_high;
        logic [7:0] accel_y_high;
        logic [7:0] accel_z_high;
        logic [7:0] low_bits_and_buttons;
    } item_t;

    typedef struct packed {
        logic [1:0] cmd_kind;
        logic [6:0] cmd_address;
        logic [7:0] cmd_first;
        logic [7:0] cmd_second;
        logic [7:0] joy_x;
        logic [7:0] joy_y;
        logic [9:0] accel_x;
        logic [9:0] accel_y;
        logic [9:0] accel_z;
        logic       button_z;
        logic       button_c;
        logic       new_data;
    } result_t;

    // Classified item as it travels from front to back
    typedef struct packed {
        op_t        op;
        logic       full_report;
        logic [7:0] joy_x;
        logic [7:0] joy_y;
        logic [9:0] accel_x;
        logic [9:0] accel_y;
        logic [9:0] accel_z;
        logic       button_z;
        logic       button_c;
    } work_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] sample_interval_ms;
        logic [7:0]  init_wait_ms;
        logic [7:0]  data_wait_ms;
        logic        accel_enable;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

// ===== design/ijps_front.sv =====
// Front end: takes items and classifies them into decoded work entries.
`default_nettype none
module ijps_front (
    input  wire ijps_pkg::item_t         item,
    input  wire                          item_valid,
    output logic                         item_ready,
    input  wire ijps_pkg::queue_status_t q_status,
    output logic                         push,
    output ijps_pkg::work_t              work
);

    logic [7:0] b5;

    assign b5         = item.low_bits_and_buttons;
    assign item_ready = !q_status.full;
    assign push       = item_valid && !q_status.full;

    always_comb
    begin
        work.op          = ijps_pkg::OP_TICK;
        case (item.kind)
            ijps_pkg::KIND_TICK: work.op = ijps_pkg::OP_TICK;
            ijps_pkg::KIND_STEP: work.op = ijps_pkg::OP_STEP;
            ijps_pkg::KIND_DATA: work.op = ijps_pkg::OP_DATA;
            ijps_pkg::KIND_TAKE: work.op = ijps_pkg::OP_TAKE;
            default:             work.op = ijps_pkg::OP_TICK;
        endcase
        work.full_report = (item.bytes_received >= ijps_pkg::REPORT_BYTES);
        work.joy_x       = item.joy_x_byte;
        work.joy_y       = item.joy_y_byte;
        work.accel_x     = {item.accel_x_high, b5[3:2]};
        work.accel_y     = {item.accel_y_high, b5[5:4]};
        work.accel_z     = {item.accel_z_high, b5[7:6]};
        // buttons are active low on the bus
        work.button_z    = ~b5[0];
        work.button_c    = ~b5[1];
    end

endmodule
`default_nettype wire

// ===== design/ijps_queue.sv =====
// Short FIFO of classified work entries between front and back.
`default_nettype none
module ijps_queue #(
    parameter int DEPTH = 2
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    input  wire ijps_pkg::work_t         push_data,
    input  wire                          pop,
    output ijps_pkg::work_t              head,
    output ijps_pkg::queue_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ijps_pkg::work_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/ijps_back.sv =====
// Back end: phase sequencer, held report values and registered result.
`default_nettype none
module ijps_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire ijps_pkg::cfg_t          cfg,
    input  wire ijps_pkg::work_t         head,
    input  wire ijps_pkg::queue_status_t q_status,
    output logic                         pop,
    output logic                         result_valid,
    input  wire                          result_ready,
    output ijps_pkg::result_t            result
);

    ijps_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       wait_reg, wait_next;
    logic [7:0]        joy_x_reg, joy_x_next;
    logic [7:0]        joy_y_reg, joy_y_next;
    logic [9:0]        accel_x_reg, accel_x_next;
    logic [9:0]        accel_y_reg, accel_y_next;
    logic [9:0]        accel_z_reg, accel_z_next;
    logic              button_z_reg, button_z_next;
    logic              button_c_reg, button_c_next;
    logic              changed_reg, changed_next;
    logic              valid_reg;
    ijps_pkg::result_t result_reg, result_next;
    ijps_pkg::cmd_t    cmd;
    logic [7:0]        cmd_first, cmd_second;
    logic              decode, accel_upd, diff, flag_out;

    assign pop          = !q_status.empty && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        decode     = 1'b0;
        case (head.op)
            ijps_pkg::OP_TICK:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - 16'd1;
                end
            end
            ijps_pkg::OP_STEP:
            begin
                case (phase_reg)
                    ijps_pkg::PH_SAMPLE_WAIT:
                        if (wait_reg == '0) phase_next = ijps_pkg::PH_INIT_WRITE;
                    ijps_pkg::PH_INIT_WAIT:
                        if (wait_reg == '0) phase_next = ijps_pkg::PH_ENC_WRITE;
                    ijps_pkg::PH_ENC_WAIT:
                        if (wait_reg == '0) phase_next = ijps_pkg::PH_REQ_WRITE;
                    ijps_pkg::PH_DATA_WAIT:
                        if (wait_reg == '0) phase_next = ijps_pkg::PH_READ_CMD;
                    ijps_pkg::PH_INIT_WRITE:
                    begin
                        wait_next  = 16'(cfg.init_wait_ms);
                        phase_next = ijps_pkg::PH_INIT_WAIT;
                    end
                    ijps_pkg::PH_ENC_WRITE:
                    begin
                        wait_next  = 16'(cfg.init_wait_ms);
                        phase_next = ijps_pkg::PH_ENC_WAIT;
                    end
                    ijps_pkg::PH_REQ_WRITE:
                    begin
                        wait_next  = 16'(cfg.data_wait_ms);
                        phase_next = ijps_pkg::PH_DATA_WAIT;
                    end
                    ijps_pkg::PH_READ_CMD:
                        phase_next = ijps_pkg::PH_AWAIT_DATA;
                    default: ;
                endcase
            end
            ijps_pkg::OP_DATA:
            begin
                if (phase_reg == ijps_pkg::PH_AWAIT_DATA)
                begin
                    decode     = head.full_report;
                    wait_next  = cfg.sample_interval_ms;
                    phase_next = ijps_pkg::PH_SAMPLE_WAIT;
                end
            end
            default: ;
        endcase
    end

    // bus command for this item
    always_comb
    begin
        cmd        = ijps_pkg::CMD_NONE;
        cmd_first  = '0;
        cmd_second = '0;
        if (head.op == ijps_pkg::OP_STEP)
        begin
            case (phase_reg)
                ijps_pkg::PH_INIT_WRITE:
                begin
                    cmd        = ijps_pkg::CMD_WRITE2;
                    cmd_first  = ijps_pkg::BYTE_INIT_REG;
                    cmd_second = ijps_pkg::BYTE_INIT_VAL;
                end
                ijps_pkg::PH_ENC_WRITE:
                begin
                    cmd        = ijps_pkg::CMD_WRITE2;
                    cmd_first  = ijps_pkg::BYTE_ENC_REG;
                    cmd_second = ijps_pkg::BYTE_ENC_VAL;
                end
                ijps_pkg::PH_REQ_WRITE:
                begin
                    cmd        = ijps_pkg::CMD_WRITE1;
                    cmd_first  = ijps_pkg::BYTE_REQ_REG;
                end
                ijps_pkg::PH_READ_CMD:
                    cmd        = ijps_pkg::CMD_READ6;
                default: ;
            endcase
        end
    end

    // held values and sticky change flag
    always_comb
    begin
        accel_upd     = decode && cfg.accel_enable;
        joy_x_next    = decode ? head.joy_x : joy_x_reg;
        joy_y_next    = decode ? head.joy_y : joy_y_reg;
        accel_x_next  = accel_upd ? head.accel_x : accel_x_reg;
        accel_y_next  = accel_upd ? head.accel_y : accel_y_reg;
        accel_z_next  = accel_upd ? head.accel_z : accel_z_reg;
        button_z_next = decode ? head.button_z : button_z_reg;
        button_c_next = decode ? head.button_c : button_c_reg;
        diff = (joy_x_next != joy_x_reg) || (joy_y_next != joy_y_reg)
            || (accel_x_next != accel_x_reg) || (accel_y_next != accel_y_reg)
            || (accel_z_next != accel_z_reg) || (button_z_next != button_z_reg)
            || (button_c_next != button_c_reg);
        flag_out     = changed_reg || diff;
        changed_next = (head.op == ijps_pkg::OP_TAKE) ? 1'b0 : flag_out;

        result_next.cmd_kind    = cmd;
        result_next.cmd_address = (cmd != ijps_pkg::CMD_NONE) ? cfg.device_address : '0;
        result_next.cmd_first   = cmd_first;
        result_next.cmd_second  = cmd_second;
        result_next.joy_x       = joy_x_next;
        result_next.joy_y       = joy_y_next;
        result_next.accel_x     = accel_x_next;
        result_next.accel_y     = accel_y_next;
        result_next.accel_z     = accel_z_next;
        result_next.button_z    = button_z_next;
        result_next.button_c    = button_c_next;
        result_next.new_data    = flag_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ijps_pkg::PH_SAMPLE_WAIT;
            wait_reg     <= '0;
            joy_x_reg    <= '0;
            joy_y_reg    <= '0;
            accel_x_reg  <= '0;
            accel_y_reg  <= '0;
            accel_z_reg  <= '0;
            button_z_reg <= 1'b0;
            button_c_reg <= 1'b0;
            changed_reg  <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                wait_reg     <= wait_next;
                joy_x_reg    <= joy_x_next;
                joy_y_reg    <= joy_y_next;
                accel_x_reg  <= accel_x_next;
                accel_y_reg  <= accel_y_next;
                accel_z_reg  <= accel_z_next;
                button_z_reg <= button_z_next;
                button_c_reg <= button_c_next;
                changed_reg  <= changed_next;
                valid_reg    <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/i2c_joystick_poll_sequencer_top.sv =====
// Top level of the I2C joystick poll sequencer: config registers, front, queue, back.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      item (ijps_pkg::item_t)
//   result    out        result_valid / result_ready  result (ijps_pkg::result_t)
//   cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One item per cycle while result_ready is high; every item gives exactly one result.
// An accepted item goes into the queue, then into the output register when it is popped.
// The QUEUE_DEPTH-item queue lets the front take items during a result stall until it fills.
// Reset puts the sequencer in the sampling wait with all held values and flags cleared.
// cfg_ready is always high.
`default_nettype none
module i2c_joystick_poll_sequencer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  item_valid,
    output logic                                 item_ready,
    input  wire ijps_pkg::item_t                 item,
    output logic                                 result_valid,
    input  wire                                  result_ready,
    output ijps_pkg::result_t                    result,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [ijps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [ijps_pkg::CFG_DATA_W-1:0]       cfg_data
);

    ijps_pkg::cfg_t          cfg_reg;
    ijps_pkg::work_t         push_work, head;
    ijps_pkg::queue_status_t q_status;
    logic                    push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address     <= ijps_pkg::RST_DEVICE_ADDRESS;
            cfg_reg.sample_interval_ms <= ijps_pkg::RST_SAMPLE_INTERVAL;
            cfg_reg.init_wait_ms       <= ijps_pkg::RST_INIT_WAIT;
            cfg_reg.data_wait_ms       <= ijps_pkg::RST_DATA_WAIT;
            cfg_reg.accel_enable       <= ijps_pkg::RST_ACCEL_ENABLE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ijps_pkg::CFG_DEVICE_ADDRESS:  cfg_reg.device_address     <= cfg_data[6:0];
                ijps_pkg::CFG_SAMPLE_INTERVAL: cfg_reg.sample_interval_ms <= cfg_data;
                ijps_pkg::CFG_INIT_WAIT:       cfg_reg.init_wait_ms       <= cfg_data[7:0];
                ijps_pkg::CFG_DATA_WAIT:       cfg_reg.data_wait_ms       <= cfg_data[7:0];
                ijps_pkg::CFG_ACCEL_ENABLE:    cfg_reg.accel_enable       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ijps_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .q_status   (q_status),
        .push       (push),
        .work       (push_work)
    );

    ijps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_work),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    ijps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.cmd_kind == ijps_pkg::CMD_NONE) |->
        (result.cmd_address == '0 && result.cmd_first == '0 && result.cmd_second == '0))
        else $error("command bytes on an item with no command");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> result_valid)
        else $error("popped item did not reach the result register");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !item_ready)
        else $error("item taken while the queue is full");

endmodule
`default_nettype wire
